[rtl/wedge15_shape_and_gradient_unit_macros.svh]
// Assertion macros for the wedge15 shape and gradient unit.
// Used by the top level only; depends on nothing.
`ifndef WEDGE15_SHAPE_AND_GRADIENT_UNIT_MACROS_SVH
`define WEDGE15_SHAPE_AND_GRADIENT_UNIT_MACROS_SVH

// clocked check, off during reset
`define W15SG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check, also active during reset
`define W15SG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/w15sg_pkg.sv]
// Package for the wedge15 shape and gradient unit: word types, widths,
// post-op codes, rounding and saturation functions. Depends on nothing.
package w15sg_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int NODE_COUNT = 15;
    localparam int NODE_W     = 4;
    localparam int OUT_W      = 20;
    localparam int OPW        = 22;
    localparam int R1W        = 28;
    localparam int PW         = R1W + OPW;
    localparam int RW         = PW - FRAC_BITS;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_COUNT - 1);
    localparam logic signed [OPW-1:0] ONE = OPW'(1 << FRAC_BITS);
    localparam logic signed [RW+1:0] OUT_MAX_X = (RW+2)'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [RW+1:0] OUT_MIN_X = -(RW+2)'(1 << (OUT_W - 1));

    typedef struct packed {
        logic signed [17:0] xi_coord;
        logic [16:0]        eta_coord;
        logic [16:0]        zeta_coord;
    } pt_word_t;

    typedef struct packed {
        logic [NODE_W-1:0]       node_index;
        logic signed [OUT_W-1:0] shape_value;
        logic signed [OUT_W-1:0] deriv_xi;
        logic signed [OUT_W-1:0] deriv_eta;
        logic signed [OUT_W-1:0] deriv_zeta;
        logic                    last_node;
    } res_word_t;

    typedef enum logic [2:0] {
        POST_ZERO,
        POST_ONE,
        POST_NEG,
        POST_HALF,
        POST_NHALF,
        POST_X2,
        POST_NX2
    } post_t;

    typedef struct packed {
        logic signed [OPW-1:0] u;
        logic signed [OPW-1:0] v;
        logic signed [OPW-1:0] w;
        logic signed [OPW-1:0] dxa;
        logic signed [OPW-1:0] dxb;
        logic signed [OPW-1:0] dya;
        logic signed [OPW-1:0] dyb;
        logic signed [OPW-1:0] dza;
        logic signed [OPW-1:0] dzb;
        post_t                 pn;
        post_t                 px;
        post_t                 py;
        post_t                 pz;
        logic [NODE_W-1:0]     node;
        logic                  last;
    } ops_t;

    // round to nearest, ties away from zero
    function automatic logic signed [RW-1:0] qround(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] r;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        r = (mag + PW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return p[PW-1] ? -RW'(r) : RW'(r);
    endfunction

    function automatic logic signed [OUT_W-1:0] post_sat(input logic signed [RW-1:0] v,
                                                         input post_t op);
        logic signed [RW+1:0] e;
        logic signed [RW+1:0] h;
        logic signed [RW+1:0] t;
        e = (RW+2)'(v);
        h = (e >= 0) ? ((e + 1) >>> 1) : -((-e + 1) >>> 1);
        case (op)
            POST_ZERO:  t = '0;
            POST_ONE:   t = e;
            POST_NEG:   t = -e;
            POST_HALF:  t = h;
            POST_NHALF: t = -h;
            POST_X2:    t = e <<< 1;
            POST_NX2:   t = -(e <<< 1);
            default:    t = '0;
        endcase
        if (t > OUT_MAX_X) begin
            t = OUT_MAX_X;
        end else if (t < OUT_MIN_X) begin
            t = OUT_MIN_X;
        end
        return OUT_W'(t);
    endfunction

endpackage

[rtl/wedge15_shape_and_gradient_unit.sv]
// Wedge15 shape and gradient unit, top level: point register, per-point
// setup, node sequencer and operand select. Depends on w15sg_pkg, w15sg_mul_pipe.
// The next point can wait in the point register while the current point is issued.
// Throughput: one node word per cycle unless m_ready stalls the output, set by the
// node sequencer that issues the 15 nodes of a point one per cycle.
// Reset: synchronous active-low aresetn clears all valid bits and the node counter.
module wedge15_shape_and_gradient_unit
    import w15sg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pt_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output res_word_t m_word
);

`include "wedge15_shape_and_gradient_unit_macros.svh"

    typedef struct packed {
        logic signed [OPW-1:0] x;
        logic signed [OPW-1:0] y;
        logic signed [OPW-1:0] z;
        logic signed [OPW-1:0] l;
        logic signed [OPW-1:0] a;
        logic signed [OPW-1:0] b;
        logic signed [OPW-1:0] s;
    } prep_t;

    pt_word_t pt_reg;
    logic     pt_valid_reg;
    prep_t    prep_reg, prep_next;
    logic     prep_valid_reg;
    logic [NODE_W-1:0] cnt_reg;
    ops_t     ops_reg, ops_next;
    logic     ops_valid_reg;

    logic adv;
    logic prep_load;
    logic last_issue;
    logic signed [2*OPW-1:0] sq_prod;
    logic signed [RW-1:0]    sq_rnd;

    assign adv        = !m_valid || m_ready;
    assign last_issue = adv && prep_valid_reg && (cnt_reg == LAST_NODE);
    assign prep_load  = pt_valid_reg && (!prep_valid_reg || last_issue);
    assign s_ready    = !pt_valid_reg || prep_load;

    always_comb begin
        prep_next.x = OPW'(pt_reg.xi_coord);
        prep_next.y = $signed({{(OPW-17){1'b0}}, pt_reg.eta_coord});
        prep_next.z = $signed({{(OPW-17){1'b0}}, pt_reg.zeta_coord});
        prep_next.l = ONE - prep_next.y - prep_next.z;
        prep_next.a = ONE - prep_next.x;
        prep_next.b = ONE + prep_next.x;
        sq_prod     = prep_next.x * prep_next.x;
        sq_rnd      = qround(PW'(sq_prod));
        prep_next.s = ONE - sq_rnd[OPW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pt_reg <= s_word;
        end
        if (prep_load) begin
            prep_reg <= prep_next;
        end
        if (adv) begin
            ops_reg <= ops_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_valid_reg   <= 1'b0;
            prep_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            ops_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pt_valid_reg <= 1'b1;
            end else if (prep_load) begin
                pt_valid_reg <= 1'b0;
            end
            if (prep_load) begin
                prep_valid_reg <= 1'b1;
            end else if (last_issue) begin
                prep_valid_reg <= 1'b0;
            end
            if (adv && prep_valid_reg) begin
                cnt_reg <= (cnt_reg == LAST_NODE) ? '0 : cnt_reg + 1'b1;
            end
            if (adv) begin
                ops_valid_reg <= prep_valid_reg;
            end
        end
    end

    // operand select per node
    always_comb begin
        logic signed [OPW-1:0] x, y, z, l, a, b, s, two;
        x   = prep_reg.x;
        y   = prep_reg.y;
        z   = prep_reg.z;
        l   = prep_reg.l;
        a   = prep_reg.a;
        b   = prep_reg.b;
        s   = prep_reg.s;
        two = ONE <<< 1;
        ops_next      = '0;
        ops_next.pn   = POST_ZERO;
        ops_next.px   = POST_ZERO;
        ops_next.py   = POST_ZERO;
        ops_next.pz   = POST_ZERO;
        ops_next.node = cnt_reg;
        ops_next.last = (cnt_reg == LAST_NODE);
        case (cnt_reg)
            4'd0: begin
                ops_next.u = y; ops_next.v = a; ops_next.w = (y <<< 1) - two - x;
                ops_next.pn = POST_HALF;
                ops_next.dxa = y; ops_next.dxb = (x <<< 1) - (y <<< 1) + ONE;
                ops_next.px = POST_HALF;
                ops_next.dya = a; ops_next.dyb = (y <<< 2) - x - two;
                ops_next.py = POST_HALF;
            end
            4'd1: begin
                ops_next.u = z; ops_next.v = a; ops_next.w = (z <<< 1) - two - x;
                ops_next.pn = POST_HALF;
                ops_next.dxa = z; ops_next.dxb = (x <<< 1) - (z <<< 1) + ONE;
                ops_next.px = POST_HALF;
                ops_next.dza = a; ops_next.dzb = (z <<< 2) - x - two;
                ops_next.pz = POST_HALF;
            end
            4'd2: begin
                ops_next.u = l; ops_next.v = a; ops_next.w = (l <<< 1) - two - x;
                ops_next.pn = POST_HALF;
                ops_next.dxa = l; ops_next.dxb = (x <<< 1) - (l <<< 1) + ONE;
                ops_next.px = POST_HALF;
                ops_next.dya = a; ops_next.dyb = (l <<< 2) - two - x;
                ops_next.py = POST_NHALF;
                ops_next.dza = a; ops_next.dzb = (l <<< 2) - two - x;
                ops_next.pz = POST_NHALF;
            end
            4'd3: begin
                ops_next.u = y; ops_next.v = b; ops_next.w = (y <<< 1) - two + x;
                ops_next.pn = POST_HALF;
                ops_next.dxa = y; ops_next.dxb = (x <<< 1) + (y <<< 1) - ONE;
                ops_next.px = POST_HALF;
                ops_next.dya = b; ops_next.dyb = (y <<< 2) + x - two;
                ops_next.py = POST_HALF;
            end
            4'd4: begin
                ops_next.u = z; ops_next.v = b; ops_next.w = (z <<< 1) - two + x;
                ops_next.pn = POST_HALF;
                ops_next.dxa = z; ops_next.dxb = (x <<< 1) + (z <<< 1) - ONE;
                ops_next.px = POST_HALF;
                ops_next.dza = b; ops_next.dzb = (z <<< 2) + x - two;
                ops_next.pz = POST_HALF;
            end
            4'd5: begin
                ops_next.u = l; ops_next.v = b; ops_next.w = (l <<< 1) - two + x;
                ops_next.pn = POST_HALF;
                ops_next.dxa = l; ops_next.dxb = (x <<< 1) + (l <<< 1) - ONE;
                ops_next.px = POST_HALF;
                ops_next.dya = b; ops_next.dyb = (l <<< 2) - two + x;
                ops_next.py = POST_NHALF;
                ops_next.dza = b; ops_next.dzb = (l <<< 2) - two + x;
                ops_next.pz = POST_NHALF;
            end
            4'd6: begin
                ops_next.u = y; ops_next.v = z; ops_next.w = a; ops_next.pn = POST_X2;
                ops_next.dxa = y; ops_next.dxb = z; ops_next.px = POST_NX2;
                ops_next.dya = a; ops_next.dyb = z; ops_next.py = POST_X2;
                ops_next.dza = a; ops_next.dzb = y; ops_next.pz = POST_X2;
            end
            4'd7: begin
                ops_next.u = z; ops_next.v = l; ops_next.w = a; ops_next.pn = POST_X2;
                ops_next.dxa = z; ops_next.dxb = l; ops_next.px = POST_NX2;
                ops_next.dya = a; ops_next.dyb = z; ops_next.py = POST_NX2;
                ops_next.dza = a; ops_next.dzb = l - z; ops_next.pz = POST_X2;
            end
            4'd8: begin
                ops_next.u = y; ops_next.v = l; ops_next.w = a; ops_next.pn = POST_X2;
                ops_next.dxa = y; ops_next.dxb = l; ops_next.px = POST_NX2;
                ops_next.dya = a; ops_next.dyb = l - y; ops_next.py = POST_X2;
                ops_next.dza = a; ops_next.dzb = y; ops_next.pz = POST_NX2;
            end
            4'd9: begin
                ops_next.u = y; ops_next.v = s; ops_next.w = ONE; ops_next.pn = POST_ONE;
                ops_next.dxa = x; ops_next.dxb = y; ops_next.px = POST_NX2;
                ops_next.dya = s; ops_next.dyb = ONE; ops_next.py = POST_ONE;
            end
            4'd10: begin
                ops_next.u = z; ops_next.v = s; ops_next.w = ONE; ops_next.pn = POST_ONE;
                ops_next.dxa = x; ops_next.dxb = z; ops_next.px = POST_NX2;
                ops_next.dza = s; ops_next.dzb = ONE; ops_next.pz = POST_ONE;
            end
            4'd11: begin
                ops_next.u = l; ops_next.v = s; ops_next.w = ONE; ops_next.pn = POST_ONE;
                ops_next.dxa = x; ops_next.dxb = l; ops_next.px = POST_NX2;
                ops_next.dya = s; ops_next.dyb = ONE; ops_next.py = POST_NEG;
                ops_next.dza = s; ops_next.dzb = ONE; ops_next.pz = POST_NEG;
            end
            4'd12: begin
                ops_next.u = y; ops_next.v = z; ops_next.w = b; ops_next.pn = POST_X2;
                ops_next.dxa = y; ops_next.dxb = z; ops_next.px = POST_X2;
                ops_next.dya = b; ops_next.dyb = z; ops_next.py = POST_X2;
                ops_next.dza = b; ops_next.dzb = y; ops_next.pz = POST_X2;
            end
            4'd13: begin
                ops_next.u = z; ops_next.v = l; ops_next.w = b; ops_next.pn = POST_X2;
                ops_next.dxa = z; ops_next.dxb = l; ops_next.px = POST_X2;
                ops_next.dya = b; ops_next.dyb = z; ops_next.py = POST_NX2;
                ops_next.dza = b; ops_next.dzb = l - z; ops_next.pz = POST_X2;
            end
            4'd14: begin
                ops_next.u = y; ops_next.v = l; ops_next.w = b; ops_next.pn = POST_X2;
                ops_next.dxa = y; ops_next.dxb = l; ops_next.px = POST_X2;
                ops_next.dya = b; ops_next.dyb = l - y; ops_next.py = POST_X2;
                ops_next.dza = b; ops_next.dzb = y; ops_next.pz = POST_NX2;
            end
            default: begin
                ops_next.pn = POST_ZERO;
            end
        endcase
    end

    w15sg_mul_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (ops_valid_reg),
        .in_ops    (ops_reg),
        .out_valid (m_valid),
        .out_word  (m_word)
    );

    `W15SG_ASSERT(a_last_is_node14, m_valid |-> (m_word.last_node == (m_word.node_index == LAST_NODE)), "last flag does not match node index")
    `W15SG_ASSERT(a_cnt_range, cnt_reg <= LAST_NODE, "node counter out of range")
    `W15SG_ASSERT(a_accept_holds_point, s_valid && s_ready |=> pt_valid_reg, "accepted point not held")
    `W15SG_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid && !prep_valid_reg, "valid bits not cleared by reset")

endmodule

[rtl/w15sg_mul_pipe.sv]
// Multiply, round and post-op pipeline for one node word per cycle while adv is high.
// Depends on w15sg_pkg.
module w15sg_mul_pipe
    import w15sg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic      in_valid,
    input  ops_t      in_ops,
    output logic      out_valid,
    output res_word_t out_word
);

    typedef struct packed {
        logic signed [2*OPW-1:0] pn;
        logic signed [2*OPW-1:0] px;
        logic signed [2*OPW-1:0] py;
        logic signed [2*OPW-1:0] pz;
        logic signed [OPW-1:0]   w;
        post_t                   cn;
        post_t                   cx;
        post_t                   cy;
        post_t                   cz;
        logic [NODE_W-1:0]       node;
        logic                    last;
    } s2_t;

    typedef struct packed {
        logic signed [R1W-1:0] rn;
        logic signed [RW-1:0]  rx;
        logic signed [RW-1:0]  ry;
        logic signed [RW-1:0]  rz;
        logic signed [OPW-1:0] w;
        post_t                 cn;
        post_t                 cx;
        post_t                 cy;
        post_t                 cz;
        logic [NODE_W-1:0]     node;
        logic                  last;
    } s3_t;

    typedef struct packed {
        logic signed [PW-1:0] pn;
        logic signed [RW-1:0] rx;
        logic signed [RW-1:0] ry;
        logic signed [RW-1:0] rz;
        post_t                cn;
        post_t                cx;
        post_t                cy;
        post_t                cz;
        logic [NODE_W-1:0]    node;
        logic                 last;
    } s4_t;

    typedef struct packed {
        logic signed [RW-1:0] rn;
        logic signed [RW-1:0] rx;
        logic signed [RW-1:0] ry;
        logic signed [RW-1:0] rz;
        post_t                cn;
        post_t                cx;
        post_t                cy;
        post_t                cz;
        logic [NODE_W-1:0]    node;
        logic                 last;
    } s5_t;

    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    res_word_t out_reg, out_next;
    logic [4:0] vld_reg;

    logic signed [RW-1:0] rn_full;

    always_comb begin
        s2_next.pn   = in_ops.u * in_ops.v;
        s2_next.px   = in_ops.dxa * in_ops.dxb;
        s2_next.py   = in_ops.dya * in_ops.dyb;
        s2_next.pz   = in_ops.dza * in_ops.dzb;
        s2_next.w    = in_ops.w;
        s2_next.cn   = in_ops.pn;
        s2_next.cx   = in_ops.px;
        s2_next.cy   = in_ops.py;
        s2_next.cz   = in_ops.pz;
        s2_next.node = in_ops.node;
        s2_next.last = in_ops.last;
    end

    always_comb begin
        rn_full      = qround(PW'(s2_reg.pn));
        s3_next.rn   = rn_full[R1W-1:0];
        s3_next.rx   = qround(PW'(s2_reg.px));
        s3_next.ry   = qround(PW'(s2_reg.py));
        s3_next.rz   = qround(PW'(s2_reg.pz));
        s3_next.w    = s2_reg.w;
        s3_next.cn   = s2_reg.cn;
        s3_next.cx   = s2_reg.cx;
        s3_next.cy   = s2_reg.cy;
        s3_next.cz   = s2_reg.cz;
        s3_next.node = s2_reg.node;
        s3_next.last = s2_reg.last;
    end

    always_comb begin
        s4_next.pn   = s3_reg.rn * s3_reg.w;
        s4_next.rx   = s3_reg.rx;
        s4_next.ry   = s3_reg.ry;
        s4_next.rz   = s3_reg.rz;
        s4_next.cn   = s3_reg.cn;
        s4_next.cx   = s3_reg.cx;
        s4_next.cy   = s3_reg.cy;
        s4_next.cz   = s3_reg.cz;
        s4_next.node = s3_reg.node;
        s4_next.last = s3_reg.last;
    end

    always_comb begin
        s5_next.rn   = qround(s4_reg.pn);
        s5_next.rx   = s4_reg.rx;
        s5_next.ry   = s4_reg.ry;
        s5_next.rz   = s4_reg.rz;
        s5_next.cn   = s4_reg.cn;
        s5_next.cx   = s4_reg.cx;
        s5_next.cy   = s4_reg.cy;
        s5_next.cz   = s4_reg.cz;
        s5_next.node = s4_reg.node;
        s5_next.last = s4_reg.last;
    end

    always_comb begin
        out_next.node_index  = s5_reg.node;
        out_next.shape_value = post_sat(s5_reg.rn, s5_reg.cn);
        out_next.deriv_xi    = post_sat(s5_reg.rx, s5_reg.cx);
        out_next.deriv_eta   = post_sat(s5_reg.ry, s5_reg.cy);
        out_next.deriv_zeta  = post_sat(s5_reg.rz, s5_reg.cz);
        out_next.last_node   = s5_reg.last;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    assign out_valid = vld_reg[4];
    assign out_word  = out_reg;

endmodule
